// ----- design/sclt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_pkg: shared types and constants of the command line tokenizer
// Transaction payloads, token kinds, quote modes and character classes.
// ----------------------------------------------------------------------------
package sclt_pkg;

	localparam int MAX_RES = 4;

	localparam logic [1:0] KIND_CHAR     = 2'd0;
	localparam logic [1:0] KIND_WORD_END = 2'd1;
	localparam logic [1:0] KIND_OP       = 2'd2;
	localparam logic [1:0] KIND_LINE_END = 2'd3;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PIPE   = 8'h7C;

	typedef enum logic [1:0] {
		QM_NORMAL = 2'd0,
		QM_DOUBLE = 2'd1,
		QM_SINGLE = 2'd2
	} quote_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_line;
	} in_item_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic [7:0] out_char;
		logic       last_of_run;
	} out_item_t;

	// All results of one input byte; last_idx points at the final one.
	typedef struct packed {
		logic [1:0]                last_idx;
		out_item_t [MAX_RES-1:0]   res;
	} bundle_t;

	function automatic logic is_blank(input logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB};
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		return b inside {CH_AMP, CH_SEMI, CH_PIPE};
	endfunction

	function automatic logic escapable(input quote_mode_t m, input logic [7:0] b);
		logic r;
		case (m)
			QM_DOUBLE: r = b inside {CH_DQUOTE, CH_BSLASH};
			QM_SINGLE: r = (b == CH_SQUOTE);
			default:   r = b inside {CH_SPACE, CH_TAB, CH_DQUOTE, CH_SQUOTE,
				CH_BSLASH, CH_AMP, CH_SEMI, CH_PIPE};
		endcase
		return r;
	endfunction

	function automatic out_item_t mk_res(input logic [1:0] kind, input logic [7:0] ch);
		out_item_t r;
		r.token_kind  = kind;
		r.out_char    = ch;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/sclt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_front: byte classifier
// Accepts one byte per cycle while the queue is not full, tracks quote and
// escape state and builds the full result bundle of the byte for the queue.
// ----------------------------------------------------------------------------
module sclt_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire sclt_pkg::in_item_t in_data,
	input  wire                  full,
	output logic                 push,
	output sclt_pkg::bundle_t    push_data
);
	import sclt_pkg::*;

	quote_mode_t mode_q, mode_d, mode_eff;
	logic        esc_q, esc_d;
	logic        wn_q, wn_d;
	logic        accept;
	logic [7:0]  b;
	logic        eol;
	logic        is_bs;
	logic        esc_lit;
	logic [2:0]  n;
	logic        word;
	out_item_t [MAX_RES-1:0] res;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.in_byte;
	assign eol      = in_data.end_of_line;
	assign is_bs    = (b == CH_BSLASH);

	always_comb begin
		case (mode_q)
			QM_DOUBLE: mode_eff = QM_DOUBLE;
			QM_SINGLE: mode_eff = QM_SINGLE;
			default:   mode_eff = QM_NORMAL;
		endcase
	end

	assign esc_lit = esc_q && escapable(mode_eff, b);

	// Next state
	always_comb begin
		mode_d = mode_eff;
		esc_d  = esc_q;
		wn_d   = wn_q;
		if (accept) begin
			if (eol) begin
				mode_d = QM_NORMAL;
				esc_d  = 1'b0;
				wn_d   = 1'b0;
			end else begin
				esc_d = is_bs && !esc_lit;
				if (esc_q) begin
					wn_d = 1'b1;
				end
				if (!esc_lit && !is_bs) begin
					case (mode_eff)
						QM_DOUBLE: begin
							if (b == CH_DQUOTE) mode_d = QM_NORMAL;
							else wn_d = 1'b1;
						end
						QM_SINGLE: begin
							if (b == CH_SQUOTE) mode_d = QM_NORMAL;
							else wn_d = 1'b1;
						end
						default: begin
							if (b == CH_DQUOTE) mode_d = QM_DOUBLE;
							else if (b == CH_SQUOTE) mode_d = QM_SINGLE;
							else if (is_blank(b) || is_op(b)) wn_d = 1'b0;
							else wn_d = 1'b1;
						end
					endcase
				end
			end
		end
	end

	// Result bundle: append results in order
	always_comb begin
		n    = 3'd0;
		word = wn_q;
		res  = '0;
		if (esc_lit) begin
			res[n[1:0]] = mk_res(KIND_CHAR, b);
			n = n + 3'd1;
			word = 1'b1;
		end else begin
			if (esc_q) begin
				res[n[1:0]] = mk_res(KIND_CHAR, CH_BSLASH);
				n = n + 3'd1;
				word = 1'b1;
			end
			if (is_bs) begin
				if (eol) begin
					res[n[1:0]] = mk_res(KIND_CHAR, CH_BSLASH);
					n = n + 3'd1;
					word = 1'b1;
				end
			end else begin
				case (mode_eff)
					QM_DOUBLE: begin
						if (b != CH_DQUOTE) begin
							res[n[1:0]] = mk_res(KIND_CHAR, b);
							n = n + 3'd1;
							word = 1'b1;
						end
					end
					QM_SINGLE: begin
						if (b != CH_SQUOTE) begin
							res[n[1:0]] = mk_res(KIND_CHAR, b);
							n = n + 3'd1;
							word = 1'b1;
						end
					end
					default: begin
						if (b == CH_DQUOTE || b == CH_SQUOTE) begin
							word = word;
						end else if (is_blank(b) || is_op(b)) begin
							if (word) begin
								res[n[1:0]] = mk_res(KIND_WORD_END, 8'h00);
								n = n + 3'd1;
							end
							word = 1'b0;
							if (is_op(b)) begin
								res[n[1:0]] = mk_res(KIND_OP, b);
								n = n + 3'd1;
							end
						end else begin
							res[n[1:0]] = mk_res(KIND_CHAR, b);
							n = n + 3'd1;
							word = 1'b1;
						end
					end
				endcase
			end
		end
		if (eol) begin
			if (word) begin
				res[n[1:0]] = mk_res(KIND_WORD_END, 8'h00);
				n = n + 3'd1;
			end
			res[n[1:0]] = mk_res(KIND_LINE_END, 8'h00);
			n = n + 3'd1;
		end
	end

	assign push               = accept && (n != 3'd0);
	assign push_data.res      = res;
	assign push_data.last_idx = n[1:0] - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= QM_NORMAL;
			esc_q  <= 1'b0;
			wn_q   <= 1'b0;
		end else begin
			mode_q <= mode_d;
			esc_q  <= esc_d;
			wn_q   <= wn_d;
		end
	end

`ifndef NO_ASSERTIONS
	// The last byte of a line leaves every piece of state cleared.
	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eol |=> mode_q == QM_NORMAL && !esc_q && !wn_q)
		else $error("state not cleared after line end");

	// A line always closes with a line end, so its bundle is never empty.
	a_eol_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eol |-> push && push_data.res[push_data.last_idx].token_kind
			== KIND_LINE_END)
		else $error("line end missing from bundle");
`endif

endmodule
`default_nettype wire

// ----- design/sclt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_queue: bundle queue
// Small register queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module sclt_queue #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire sclt_pkg::bundle_t push_data,
	output logic                full,
	input  wire                 pop,
	output sclt_pkg::bundle_t   head,
	output logic                empty
);
	import sclt_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)  rd_ptr_q <= nxt(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !empty |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers disagree with fill count");
`endif

endmodule
`default_nettype wire

// ----- design/sclt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclt_back: result serializer
// Walks the head bundle one result per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module sclt_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sclt_pkg::bundle_t head,
	input  wire                  empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output sclt_pkg::out_item_t  out_data
);
	import sclt_pkg::*;

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load      = !empty && (!out_valid_q || out_ready);
	assign at_last   = (idx_q == head.last_idx);
	assign pop       = load && at_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= '{token_kind:  head.res[idx_q].token_kind,
				out_char:    head.res[idx_q].out_char,
				last_of_run: at_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// Never walk past the final result of the head bundle.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> idx_q <= head.last_idx)
		else $error("result index beyond bundle");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0)
		else $error("index not rewound after pop");
`endif

endmodule
`default_nettype wire

// ----- design/shell_command_line_tokenizer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_unit: streaming command line tokenizer
// Turns command line bytes into word characters, word ends, operator tokens
// and line ends, honoring double quotes, single quotes and backslashes.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one byte per transaction, with
//   end_of_line set on the final byte of a line. out_valid/out_ready/out_data
//   carry one token per transaction; last_of_run marks the final token that
//   a byte produced. A byte may produce no token at all (quotes, a held
//   backslash, a blank after a blank).
//   The first token of a byte goes into the bundle queue at the edge that
//   accepted the byte, then into the output register. Throughput: one byte
//   per cycle in while the queue has room, one token per cycle out while
//   out_ready is high; the bundle queue of QUEUE_DEPTH entries absorbs
//   multi-token bursts. in_ready drops only while the queue is full.
//   Reset clears quote mode, held backslash, word state, queue and output.
//   A stalled receiver holds the output register; the queue keeps filling
//   until full, then in_ready falls.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire sclt_pkg::in_item_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output sclt_pkg::out_item_t  out_data
);
	import sclt_pkg::*;

	// Bundle transactions between classifier and serializer
	bundle_t push_data;
	bundle_t head;
	logic    push;
	logic    pop;
	logic    full;
	logic    empty;

	// Classify each byte and build its complete token bundle
	sclt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple byte intake from token delivery
	sclt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Drain one token per cycle into the output register unless stalled
	sclt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// A held output token stays put until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output token changed while stalled");
`endif

endmodule
`default_nettype wire
